>>> rtl/core/ste_pkg.sv
// Package for the spherical triangle excess block: formats, constants and step functions.
package ste_pkg;

    localparam int SQ_STEPS     = 32;
    localparam int UDIV_STEPS   = 31;
    localparam int RATIO_STEPS  = 30;
    localparam int CORDIC_STEPS = 32;
    localparam int CW           = 36;
    localparam int ZW           = 44;

    localparam logic [63:0] ONE_Q60        = 64'd1 << 60;
    localparam logic [30:0] ONE_Q30        = 31'd1 << 30;
    localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
    localparam logic [63:0] QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;
    localparam logic signed [ZW-1:0] PI_Q40 = ZW'((PI_Q60 + 64'd524288) >> 20);

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } t_sq;

    typedef struct packed {
        logic [63:0] rem;
        logic [30:0] q;
    } t_dv;

    typedef struct packed {
        logic [63:0] rem;
        logic [29:0] q;
    } t_rt;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cr;

    // Shift-and-subtract division, used only to build constants at elaboration.
    function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) from the truncated Taylor series in 2^-60 units, rounded to 2^-40.
    function automatic logic signed [ZW-1:0] atan_q40(input int i);
        logic signed [63:0] v;
        logic [63:0]        t;
        logic               done;
        int                 d;
        int                 n;
        v    = '0;
        done = 1'b0;
        if (i == 0) begin
            v = $signed(QUARTER_PI_Q60);
        end else begin
            for (int k = 0; k < 31; k++) begin
                d = 2 * k + 1;
                n = i * d;
                if (!done) begin
                    if (n > 60) begin
                        done = 1'b1;
                    end else begin
                        t = const_udiv(64'd1 << (60 - n), 64'(d));
                        if (k % 2 == 1) begin
                            v = v - $signed(t);
                        end else begin
                            v = v + $signed(t);
                        end
                    end
                end
            end
        end
        return ZW'((v + 64'sd524288) >>> 20);
    endfunction

    // One bit of the integer square root.
    function automatic t_sq sq_step(input t_sq c, input int s);
        logic [63:0] b;
        logic [63:0] t;
        t_sq         o;
        b = 64'd1 << (62 - 2 * s);
        t = c.r + b;
        if (c.v >= t) begin
            o.v = c.v - t;
            o.r = (c.r >> 1) + b;
        end else begin
            o.v = c.v;
            o.r = c.r >> 1;
        end
        return o;
    endfunction

    // One quotient bit of the normalizing division.
    function automatic t_dv udiv_step(input t_dv c, input logic [31:0] norm, input int k);
        logic [63:0] dsh;
        t_dv         o;
        dsh = 64'(norm) << k;
        o   = c;
        if (c.rem >= dsh) begin
            o.rem = c.rem - dsh;
            o.q   = c.q | (31'd1 << k);
        end
        return o;
    endfunction

    // One quotient bit of the cosine-law ratio.
    function automatic t_rt ratio_step(input t_rt c, input logic [60:0] den);
        logic [63:0] r2;
        t_rt         o;
        r2 = c.rem << 1;
        if (r2 >= 64'(den)) begin
            o.rem = r2 - 64'(den);
            o.q   = {c.q[28:0], 1'b1};
        end else begin
            o.rem = r2;
            o.q   = {c.q[28:0], 1'b0};
        end
        return o;
    endfunction

    // One CORDIC vectoring rotation.
    function automatic t_cr cordic_step(input t_cr c, input int i,
                                        input logic signed [ZW-1:0] at);
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        t_cr                  o;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (c.y > 0) begin
            o.x = c.x + dx;
            o.y = c.y - dy;
            o.z = c.z + at;
        end else begin
            o.x = c.x - dx;
            o.y = c.y + dy;
            o.z = c.z - at;
        end
        return o;
    endfunction

    function automatic logic signed [63:0] mul_s32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p;
    endfunction

    function automatic logic [61:0] mul_u31(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = a * b;
        return p;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] c);
        return c[31] ? (~32'(c)) + 32'd1 : 32'(c);
    endfunction

    function automatic logic [61:0] mag64(input logic signed [63:0] c);
        logic [63:0] m;
        m = c[63] ? (~64'(c)) + 64'd1 : 64'(c);
        return m[61:0];
    endfunction

    // Clamp a unit component to one and give it its sign.
    function automatic logic signed [31:0] unit_fix(input logic [30:0] q, input logic neg);
        logic [31:0] u;
        u = {1'b0, (q > ONE_Q30) ? ONE_Q30 : q};
        return $signed(neg ? 32'd0 - u : u);
    endfunction

    // Round a Q4.60 dot product to Q2.30 and clamp it to [-1, 1].
    function automatic logic signed [31:0] cos_fix(input logic signed [63:0] s);
        logic signed [63:0] t;
        t = (s + 64'sd536870912) >>> 30;
        if (t > 64'sd1073741824) begin
            t = 64'sd1073741824;
        end else if (t < -64'sd1073741824) begin
            t = -64'sd1073741824;
        end
        return 32'(t);
    endfunction

    // Round the ratio quotient half up and clamp it to one.
    function automatic logic [30:0] ratio_fix(input t_rt c, input logic [60:0] den,
                                              input logic big);
        logic [30:0] q;
        q = {1'b0, c.q} + 31'(((c.rem << 1) >= 64'(den)) ? 1 : 0);
        if (q > ONE_Q30 || big) begin
            q = ONE_Q30;
        end
        return q;
    endfunction

    function automatic logic signed [ZW-1:0] acos_fix(input logic signed [ZW-1:0] z,
                                                      input logic neg);
        logic signed [ZW-1:0] zc;
        zc = (z < 0) ? '0 : z;
        return neg ? PI_Q40 - zc : zc;
    endfunction

endpackage

>>> rtl/core/spherical_triangle_excess_top.sv
// Spherical triangle excess (Girard) pipeline, one triangle per clock unless the output stalls.
//
//  channel  | dir | beat contents (lowest bits first)
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z, 32 bits each
//  m_axis   | out | tdata: excess_angle (32); tuser: degenerate (1)
//
// Accepted beats leave in the order they came; a new beat may enter on every
// clock while the output is taken, so the sustained rate is one triangle per cycle.
// Most stages lie in the four bit-per-stage loops: three 32-step square roots and
// the CORDIC arc cosine, plus the 31- and 30-step long divisions.
// Reset clears only the valid bits of the pipeline; data registers hold no state.
// When the output beat is not taken, the whole pipeline holds, s_axis_tready
// drops, and nothing is dropped or repeated.
module spherical_triangle_excess_top
    import ste_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // excess_angle
    output logic         m_axis_tuser    // degenerate
);

    localparam int LAT = 3 + SQ_STEPS + 1 + UDIV_STEPS + 6 + SQ_STEPS + 2 + RATIO_STEPS
                       + 3 + SQ_STEPS + CORDIC_STEPS + 3;

    logic [LAT-1:0] r_vld;
    logic           adv;

    // The pipeline moves as one piece whenever the output stage can take a beat.
    assign adv           = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // Input capture, coordinate squares and squared norms.
    logic signed [31:0] r_in [9];
    logic        [62:0] r_sq [9];
    logic signed [31:0] r_c2 [9];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                r_in[k] <= s_axis_tdata[32*k +: 32];
                r_sq[k] <= 63'(mul_s32(r_in[k], r_in[k]));
                r_c2[k] <= r_in[k];
            end
        end
    end

    // Norm square roots, one root bit per stage, coordinates travel alongside.
    t_sq                r_nq [SQ_STEPS+1][3];
    logic signed [31:0] r_nc [SQ_STEPS+1][9];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_nq[0][j].v <= 64'(r_sq[3*j]) + 64'(r_sq[3*j+1]) + 64'(r_sq[3*j+2]);
                r_nq[0][j].r <= '0;
            end
            r_nc[0] <= r_c2;
        end
    end

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_norm
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int j = 0; j < 3; j++) begin
                    r_nq[s+1][j] <= sq_step(r_nq[s][j], s);
                end
                r_nc[s+1] <= r_nc[s];
            end
        end
    end

    // Unit vector components: round(|c| * 2^30 / norm) by long division.
    t_dv         r_dv  [UDIV_STEPS+1][9];
    logic [31:0] r_dn  [UDIV_STEPS+1][3];
    logic        r_dsg [UDIV_STEPS+1][9];
    logic        r_ddg [UDIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                r_dv[0][k].rem <= {2'b00, mag32(r_nc[SQ_STEPS][k]), 30'd0}
                                + 64'(r_nq[SQ_STEPS][k/3].r[31:1]);
                r_dv[0][k].q   <= '0;
                r_dsg[0][k]    <= r_nc[SQ_STEPS][k][31];
            end
            for (int j = 0; j < 3; j++) begin
                r_dn[0][j] <= r_nq[SQ_STEPS][j].r[31:0];
            end
            // A vertex at the origin has a zero norm.
            r_ddg[0] <= (r_nq[SQ_STEPS][0].r[31:0] == '0)
                     || (r_nq[SQ_STEPS][1].r[31:0] == '0)
                     || (r_nq[SQ_STEPS][2].r[31:0] == '0);
        end
    end

    for (genvar s = 0; s < UDIV_STEPS; s++) begin : g_udiv
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int k = 0; k < 9; k++) begin
                    r_dv[s+1][k] <= udiv_step(r_dv[s][k], r_dn[s][k/3], UDIV_STEPS - 1 - s);
                end
                r_dn[s+1]  <= r_dn[s];
                r_dsg[s+1] <= r_dsg[s];
                r_ddg[s+1] <= r_ddg[s];
            end
        end
    end

    // Unit vectors, pairwise dot products and side cosines.
    logic signed [31:0] r_u  [9];
    logic signed [63:0] r_pd [9];
    logic signed [63:0] r_ds [3];
    logic signed [31:0] r_cs [3];
    logic        [60:0] r_cq [3];
    logic signed [63:0] r_cp [3];
    logic signed [31:0] r_c3 [3];
    logic               r_udg;
    logic               r_pdg;
    logic               r_sdg0;
    logic               r_cdg;
    logic               r_qdg;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                r_u[k] <= unit_fix(r_dv[UDIV_STEPS][k].q, r_dsg[UDIV_STEPS][k]);
            end
            r_udg <= r_ddg[UDIV_STEPS];
            // Side a joins b and c, side b joins a and c, side c joins a and b.
            for (int m = 0; m < 3; m++) begin
                r_pd[m]   <= mul_s32(r_u[3+m], r_u[6+m]);
                r_pd[3+m] <= mul_s32(r_u[m],   r_u[6+m]);
                r_pd[6+m] <= mul_s32(r_u[m],   r_u[3+m]);
            end
            r_pdg <= r_udg;
            for (int i = 0; i < 3; i++) begin
                r_ds[i] <= r_pd[3*i] + r_pd[3*i+1] + r_pd[3*i+2];
                r_cs[i] <= cos_fix(r_ds[i]);
                r_cq[i] <= 61'(mul_s32(r_cs[i], r_cs[i]));
                r_c3[i] <= r_cs[i];
            end
            r_sdg0  <= r_pdg;
            r_cdg   <= r_sdg0;
            r_cp[0] <= mul_s32(r_cs[1], r_cs[2]);
            r_cp[1] <= mul_s32(r_cs[0], r_cs[2]);
            r_cp[2] <= mul_s32(r_cs[0], r_cs[1]);
            r_qdg   <= r_cdg;
        end
    end

    // Side sines by square root; the cosine-law numerators travel alongside.
    t_sq                r_sn   [SQ_STEPS+1][3];
    logic signed [63:0] r_snum [SQ_STEPS+1][3];
    logic               r_sdg  [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_sn[0][i].v  <= ONE_Q60 - 64'(r_cq[i]);
                r_sn[0][i].r  <= '0;
                r_snum[0][i]  <= (64'(r_c3[i]) <<< 30) - r_cp[i];
            end
            r_sdg[0] <= r_qdg;
        end
    end

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sine
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int i = 0; i < 3; i++) begin
                    r_sn[s+1][i] <= sq_step(r_sn[s][i], s);
                end
                r_snum[s+1] <= r_snum[s];
                r_sdg[s+1]  <= r_sdg[s];
            end
        end
    end

    // Denominators are products of the two adjacent side sines.
    logic        [60:0] r_dd   [3];
    logic signed [63:0] r_dnum [3];
    logic               r_dddg;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dd[0] <= 61'(mul_u31(r_sn[SQ_STEPS][1].r[30:0], r_sn[SQ_STEPS][2].r[30:0]));
            r_dd[1] <= 61'(mul_u31(r_sn[SQ_STEPS][0].r[30:0], r_sn[SQ_STEPS][2].r[30:0]));
            r_dd[2] <= 61'(mul_u31(r_sn[SQ_STEPS][0].r[30:0], r_sn[SQ_STEPS][1].r[30:0]));
            r_dnum  <= r_snum[SQ_STEPS];
            // Coincident or antipodal vertices leave a zero sine.
            r_dddg  <= r_sdg[SQ_STEPS]
                    || (r_sn[SQ_STEPS][0].r[30:0] == '0)
                    || (r_sn[SQ_STEPS][1].r[30:0] == '0)
                    || (r_sn[SQ_STEPS][2].r[30:0] == '0);
        end
    end

    // Arc-cosine arguments |num| * 2^30 / den, saturated at one.
    t_rt         r_rt   [RATIO_STEPS+1][3];
    logic [60:0] r_rden [RATIO_STEPS+1][3];
    logic        r_rbig [RATIO_STEPS+1][3];
    logic        r_rneg [RATIO_STEPS+1][3];
    logic        r_rdg  [RATIO_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_rt[0][i].rem <= 64'(mag64(r_dnum[i]));
                r_rt[0][i].q   <= '0;
                r_rbig[0][i]   <= 64'(mag64(r_dnum[i])) >= 64'(r_dd[i]);
                r_rneg[0][i]   <= r_dnum[i][63];
                r_rden[0][i]   <= r_dd[i];
            end
            r_rdg[0] <= r_dddg;
        end
    end

    for (genvar s = 0; s < RATIO_STEPS; s++) begin : g_ratio
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int i = 0; i < 3; i++) begin
                    r_rt[s+1][i] <= ratio_step(r_rt[s][i], r_rden[s][i]);
                end
                r_rden[s+1] <= r_rden[s];
                r_rbig[s+1] <= r_rbig[s];
                r_rneg[s+1] <= r_rneg[s];
                r_rdg[s+1]  <= r_rdg[s];
            end
        end
    end

    // Argument magnitude, its square, then the opposite leg sqrt(1 - r^2).
    logic [30:0] r_m     [3];
    logic        r_mneg  [3];
    logic        r_mdg;
    logic [60:0] r_mm    [3];
    logic [30:0] r_mm_m  [3];
    logic        r_mm_ng [3];
    logic        r_mmdg;
    logic [30:0] n_q     [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_q[i] = ratio_fix(r_rt[RATIO_STEPS][i], r_rden[RATIO_STEPS][i],
                               r_rbig[RATIO_STEPS][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_m[i]     <= n_q[i];
                // A quotient that rounds to zero is no longer negative.
                r_mneg[i]  <= r_rneg[RATIO_STEPS][i] && (n_q[i] != '0);
                r_mm[i]    <= 61'(mul_u31(r_m[i], r_m[i]));
                r_mm_m[i]  <= r_m[i];
                r_mm_ng[i] <= r_mneg[i];
            end
            r_mdg  <= r_rdg[RATIO_STEPS];
            r_mmdg <= r_mdg;
        end
    end

    t_sq         r_aq   [SQ_STEPS+1][3];
    logic [30:0] r_am   [SQ_STEPS+1][3];
    logic        r_aneg [SQ_STEPS+1][3];
    logic        r_adg  [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_aq[0][i].v <= ONE_Q60 - 64'(r_mm[i]);
                r_aq[0][i].r <= '0;
            end
            r_am[0]   <= r_mm_m;
            r_aneg[0] <= r_mm_ng;
            r_adg[0]  <= r_mmdg;
        end
    end

    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_aleg
        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int i = 0; i < 3; i++) begin
                    r_aq[s+1][i] <= sq_step(r_aq[s][i], s);
                end
                r_am[s+1]   <= r_am[s];
                r_aneg[s+1] <= r_aneg[s];
                r_adg[s+1]  <= r_adg[s];
            end
        end
    end

    // CORDIC vectoring: the angle of (|r|, sqrt(1 - r^2)) in 2^-40 rad.
    t_cr  w_kin  [3];
    t_cr  r_kc   [CORDIC_STEPS][3];
    logic r_kneg [CORDIC_STEPS][3];
    logic r_kdg  [CORDIC_STEPS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_kin[i].x = CW'({1'b0, r_am[SQ_STEPS][i]});
            w_kin[i].y = CW'({1'b0, r_aq[SQ_STEPS][i].r[30:0]});
            w_kin[i].z = '0;
        end
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN_S = atan_q40(s);
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    for (int i = 0; i < 3; i++) begin
                        r_kc[0][i] <= cordic_step(w_kin[i], s, ATAN_S);
                    end
                    r_kneg[0] <= r_aneg[SQ_STEPS];
                    r_kdg[0]  <= r_adg[SQ_STEPS];
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (adv) begin
                    for (int i = 0; i < 3; i++) begin
                        r_kc[s][i] <= cordic_step(r_kc[s-1][i], s, ATAN_S);
                    end
                    r_kneg[s] <= r_kneg[s-1];
                    r_kdg[s]  <= r_kdg[s-1];
                end
            end
        end
    end

    // Corner angles, their sum less pi, and rounding to Q4.28.
    logic signed [ZW-1:0] r_ang [3];
    logic                 r_fdg;
    logic signed [ZW-1:0] r_e;
    logic                 r_edg;
    logic signed [ZW-1:0] n_er;
    logic        [31:0]   r_out;
    logic                 r_odeg;

    assign n_er = (r_e + ZW'(2048)) >>> 12;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_ang[i] <= acos_fix(r_kc[CORDIC_STEPS-1][i].z, r_kneg[CORDIC_STEPS-1][i]);
            end
            r_fdg  <= r_kdg[CORDIC_STEPS-1];
            r_e    <= r_ang[0] + r_ang[1] + r_ang[2] - PI_Q40;
            r_edg  <= r_fdg;
            r_out  <= r_edg ? 32'd0 : n_er[31:0];
            r_odeg <= r_edg;
        end
    end

    assign m_axis_tdata = r_out;
    assign m_axis_tuser = r_odeg;

    // A degenerate triangle always reports a zero excess.
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("degenerate beat carries a nonzero excess");

    // A held output beat freezes the whole pipeline, input side included.
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while the output beat is held");

    // Every accepted beat enters the first pipeline stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted beat lost at the pipeline entry");

    // A held output beat is still there at the next edge.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(r_odeg))
        else $error("held output beat changed");

endmodule

>>> sim/spherical_triangle_excess_top_test.sv
// Self-checking testbench for the spherical triangle excess pipeline.
module spherical_triangle_excess_top_test;

    // One expected output beat: the excess angle in Q4.28 and the degenerate flag.
    typedef struct packed {
        logic [31:0] angle;
        logic        degen;
    } t_excess;

    typedef logic signed [31:0] t_coord;

    // Scoreboard: predicts the excess for every accepted triangle and checks the
    // output beats against those predictions in order.
    class excess_scoreboard;
        t_excess     pending_q[$];
        longint      atan_tab[32];
        longint      pi_q40;
        int          n_errors;
        int          n_checked;
        int          n_degen;

        function new();
            longint     v;
            longint     t;
            int         d;
            int         n;
            for (int i = 0; i < 32; i++) begin
                v = 0;
                if (i == 0) begin
                    v = 64'h0C90FDAA22168C23;
                end else begin
                    for (int k = 0; k < 31; k++) begin
                        d = 2 * k + 1;
                        n = i * d;
                        if (n > 60) break;
                        t = longint'((64'd1 << (60 - n)) / 64'(d));
                        v = (k % 2 == 1) ? v - t : v + t;
                    end
                end
                atan_tab[i] = (v + (64'sd1 <<< 19)) >>> 20;
            end
            pi_q40 = (64'sh3243F6A8885A308D + (64'sd1 <<< 19)) >>> 20;
            n_errors  = 0;
            n_checked = 0;
            n_degen   = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Arc cosine of a Q2.30 value, in units of 2^-40 rad, by CORDIC vectoring.
        function longint arc_cos(longint r);
            longint m;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            m = (r < 0) ? -r : r;
            x = m;
            y = longint'(int_sqrt((64'd1 << 60) - 64'(m) * 64'(m)));
            z = 0;
            for (int i = 0; i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x = x + dx; y = y - dy; z = z + atan_tab[i];
                end else begin
                    x = x - dx; y = y + dy; z = z - atan_tab[i];
                end
            end
            if (z < 0) z = 0;
            if (r < 0) z = pi_q40 - z;
            return z;
        endfunction

        // Projects a vertex onto the unit sphere; returns 0 for the origin.
        function bit to_unit(t_coord p[3], output longint u[3]);
            longint          c;
            longint unsigned sq;
            longint unsigned norm;
            longint unsigned mag;
            longint unsigned q;
            sq = 0;
            for (int j = 0; j < 3; j++) begin
                c  = longint'(p[j]);
                sq = sq + 64'(c * c);
            end
            if (sq == 0) return 0;
            norm = int_sqrt(sq);
            for (int j = 0; j < 3; j++) begin
                c   = longint'(p[j]);
                mag = 64'((c < 0) ? -c : c);
                q   = ((mag << 30) + norm / 2) / norm;
                if (q > (64'd1 << 30)) q = 64'd1 << 30;
                u[j] = (c < 0) ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function longint cosine(longint u[3], longint w[3]);
            longint s;
            s = u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
            s = (s + (64'sd1 <<< 29)) >>> 30;
            if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
            if (s < -(64'sd1 <<< 30)) s = -(64'sd1 <<< 30);
            return s;
        endfunction

        // Corner angle from the spherical law of cosines, argument clamped to [-1, 1].
        function longint corner(longint ca, longint cb, longint cc,
                                longint unsigned sb, longint unsigned sc);
            longint          num;
            longint unsigned den;
            longint unsigned mag;
            longint unsigned q;
            num = ca * (64'sd1 <<< 30) - cb * cc;
            den = sb * sc;
            mag = 64'((num < 0) ? -num : num);
            q   = 0;
            if (mag >= den) begin
                q = 64'd1 << 30;
            end else begin
                for (int i = 0; i < 30; i++) begin
                    mag = mag << 1;
                    q   = q << 1;
                    if (mag >= den) begin
                        mag = mag - den;
                        q   = q | 64'd1;
                    end
                end
                if ((mag << 1) >= den) q = q + 1;
                if (q > (64'd1 << 30)) q = 64'd1 << 30;
            end
            return arc_cos((num < 0) ? -longint'(q) : longint'(q));
        endfunction

        // Notes an accepted triangle and queues its predicted excess.
        function void note_triangle(logic [287:0] beat);
            t_coord          va[3];
            t_coord          vb[3];
            t_coord          vc[3];
            longint          ua[3];
            longint          ub[3];
            longint          uc[3];
            longint          ca;
            longint          cb;
            longint          cc;
            longint          e;
            longint unsigned sa;
            longint unsigned sb;
            longint unsigned sc;
            bit              ok;
            t_excess         res;
            for (int j = 0; j < 3; j++) begin
                va[j] = beat[32 * j +: 32];
                vb[j] = beat[32 * (j + 3) +: 32];
                vc[j] = beat[32 * (j + 6) +: 32];
            end
            ok = 1;
            e  = 0;
            ok = to_unit(va, ua) & ok;
            ok = to_unit(vb, ub) & ok;
            ok = to_unit(vc, uc) & ok;
            if (ok) begin
                ca = cosine(ub, uc);
                cb = cosine(ua, uc);
                cc = cosine(ua, ub);
                sa = int_sqrt((64'd1 << 60) - 64'(ca * ca));
                sb = int_sqrt((64'd1 << 60) - 64'(cb * cb));
                sc = int_sqrt((64'd1 << 60) - 64'(cc * cc));
                if (sa == 0 || sb == 0 || sc == 0) begin
                    ok = 0;
                end else begin
                    e = corner(ca, cb, cc, sb, sc) + corner(cb, ca, cc, sa, sc)
                      + corner(cc, ca, cb, sa, sb) - pi_q40;
                    e = (e + (64'sd1 <<< 11)) >>> 12;
                end
            end
            res.angle = ok ? e[31:0] : 32'd0;
            res.degen = !ok;
            pending_q.push_back(res);
        endfunction

        task report_mismatch(string what);
            $display("ERROR: %s", what);
            n_errors++;
        endtask

        // Checks one output beat against the oldest prediction.
        task check_beat(logic [31:0] angle, logic degen);
            t_excess want;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat angle=%h degen=%b", angle, degen));
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            if (degen) n_degen++;
            if (angle !== want.angle)
                report_mismatch($sformatf("beat %0d: angle %h, expected %h",
                                          n_checked, angle, want.angle));
            if (degen !== want.degen)
                report_mismatch($sformatf("beat %0d: degenerate %b, expected %b",
                                          n_checked, degen, want.degen));
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;   // excess_angle
    logic         m_axis_tuser;   // degenerate

    excess_scoreboard sb;
    int               idle_pct;   // chance in a hundred that either side idles
    int               n_sent;

    spherical_triangle_excess_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // A generous time limit ends a run that hangs; a correct run ends well within it.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The receiver stalls at random; every accepted output beat is checked.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser);
    end

    // Offers one triangle, with random idle cycles ahead of it, and holds it until
    // the beat is taken. Returns at the falling edge after acceptance.
    task automatic send_triangle(t_coord v[9]);
        logic [287:0] beat;
        for (int j = 0; j < 9; j++) beat[32 * j +: 32] = v[j];
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_triangle(beat);
        n_sent++;
        @(negedge i_clk);
    endtask

    // A coordinate whose magnitude is bounded by a random power of two, so that
    // vertices span everything from tiny to half of full scale.
    function automatic t_coord rand_coord();
        int k;
        k = $urandom_range(31, 2);
        return $signed($urandom_range((1 << (k - 1)) - 1, 0)) * ($urandom_range(1) ? -1 : 1);
    endfunction

    task automatic send_random();
        t_coord v[9];
        int     kind;
        int     s;
        kind = $urandom_range(99);
        for (int j = 0; j < 9; j++) v[j] = (kind < 30) ? t_coord'($urandom) : rand_coord();
        if (kind >= 80) begin
            // Broken triangles: a vertex at the origin, repeated, scaled or mirrored.
            s = 3 * $urandom_range(2);
            case ($urandom_range(3))
                0: for (int j = 0; j < 3; j++) v[s + j] = '0;
                1: for (int j = 0; j < 3; j++) v[s + j] = v[(s + 3) % 9 + j];
                2: for (int j = 0; j < 3; j++) v[s + j] = v[(s + 3) % 9 + j] >>> 1;
                default: for (int j = 0; j < 3; j++) v[s + j] = -v[(s + 3) % 9 + j];
            endcase
        end
        send_triangle(v);
    endtask

    task automatic wait_drained();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    localparam t_coord ONE  = 32'sh0001_0000;
    localparam t_coord MAXC = 32'sh7FFF_FFFF;
    localparam t_coord MINC = 32'sh8000_0000;

    initial begin
        t_coord dir[25][9];
        sb            = new();
        idle_pct      = 12;
        n_sent        = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed triangles: the octant triangle, extremes, origin vertices,
        // coincident and antipodal vertices, and nearly flat triangles.
        dir[0]  = '{ONE, 0, 0,  0, ONE, 0,  0, 0, ONE};
        dir[1]  = '{0, 0, 0,  0, ONE, 0,  0, 0, ONE};
        dir[2]  = '{ONE, 0, 0,  0, 0, 0,  0, 0, ONE};
        dir[3]  = '{ONE, 0, 0,  0, ONE, 0,  0, 0, 0};
        dir[4]  = '{ONE, 0, 0,  ONE, 0, 0,  0, 0, ONE};
        dir[5]  = '{ONE, 0, 0,  -ONE, 0, 0,  0, 0, ONE};
        dir[6]  = '{MAXC, 0, 0,  0, MAXC, 0,  0, 0, MAXC};
        dir[7]  = '{MINC, 0, 0,  0, MINC, 0,  0, 0, MINC};
        dir[8]  = '{MAXC, MAXC, MAXC,  MINC, MAXC, MINC,  MAXC, MINC, MINC};
        dir[9]  = '{MINC, MINC, MINC,  MINC, MINC, MAXC,  MAXC, MINC, MINC};
        dir[10] = '{1, 0, 0,  0, 1, 0,  0, 0, 1};
        dir[11] = '{-1, -1, -1,  1, -1, 1,  -1, 1, 1};
        dir[12] = '{ONE, 0, 0,  ONE, 1, 0,  ONE, 0, 1};
        dir[13] = '{ONE, 0, 0,  0, ONE, 0,  -ONE, -ONE, 0};
        dir[14] = '{ONE, ONE, 0,  ONE, -ONE, 0,  -ONE, 0, ONE};
        dir[15] = '{ONE, 0, 0,  0, ONE, 0,  ONE, ONE, 0};
        dir[16] = '{ONE, 0, 0,  0, ONE, 0,  -ONE, 0, 0};
        dir[17] = '{-1, 0, 0,  0, 0, 0,  0, 0, 0};
        dir[18] = '{3 * ONE, 4 * ONE, 0,  0, 0, 5 * ONE,  -4 * ONE, 3 * ONE, 0};
        dir[19] = '{ONE, 2, 3,  ONE, 3, 2,  ONE, -2, -3};
        dir[20] = '{MAXC, 1, 1,  1, MAXC, 1,  1, 1, MAXC};
        dir[21] = '{32'sh0000_FFFF, 32'shFFFF_0000, 32'sh5555_5555,
                    32'shAAAA_AAAA, 32'sh0F0F_0F0F, 32'shF0F0_F0F0,
                    32'sh3333_3333, 32'shCCCC_CCCC, 32'sh7FFF_0001};
        dir[22] = '{0, 0, ONE,  0, 0, ONE,  0, 0, ONE};
        dir[23] = '{0, 0, ONE,  0, 0, 2 * ONE,  ONE, 0, 0};
        dir[24] = '{ONE, ONE, ONE,  -ONE, ONE, -ONE,  ONE, -ONE, -ONE};
        for (int i = 0; i < 25; i++) send_triangle(dir[i]);

        for (int i = 0; i < 1650; i++) begin
            // A back-to-back stretch with neither side idling.
            idle_pct = (i >= 300 && i < 700) ? 0 : 12;
            if (i == 900) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            send_random();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);

        $display("Run covered %0d triangles, %0d output beats checked, %0d of them degenerate.",
                 n_sent, sb.n_checked, sb.n_degen);
        if (sb.n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
